[src/upe_pkg.sv]
// Shared types, constants and character-class functions for the URI path percent-encoder.
`timescale 1ns / 1ps

package upe_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH   = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_ENCODE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEGACY_MODE   = 8'd1;

   // Output bytes per input byte: 1, 3 or 5
   localparam int unsigned BEAT_COUNT_WIDTH = 3;
   localparam logic [BEAT_COUNT_WIDTH-1:0] LEN_PLAIN   = 3'd1;
   localparam logic [BEAT_COUNT_WIDTH-1:0] LEN_ESCAPE  = 3'd3;
   localparam logic [BEAT_COUNT_WIDTH-1:0] LEN_DOUBLE  = 3'd5;

   // ASCII characters used in escapes
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_TWO     = 8'h32;
   localparam logic [7:0] CHAR_FIVE    = 8'h35;

   // One output byte with its end-of-item flag
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } upe_beat_type;

   // Uppercase hexadecimal digit for a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      if (nibble < 4'd10) begin
         digit = 8'h30 + {4'd0, nibble};
      end else begin
         digit = 8'h37 + {4'd0, nibble};
      end
      return digit;
   endfunction

   // Letters, digits and - _ . ~ / always pass unchanged
   function automatic logic is_unreserved(input logic [7:0] b);
      logic hit;
      hit = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
            ((b >= 8'h30) && (b <= 8'h39)) ||
            (b == 8'h2D) || (b == 8'h5F) || (b == 8'h2E) || (b == 8'h7E) || (b == 8'h2F);
      return hit;
   endfunction

   // Sub-delimiters $ & , : ; = @ pass only in legacy mode with double encoding off
   function automatic logic is_sub_delim(input logic [7:0] b);
      logic hit;
      hit = (b == 8'h24) || (b == 8'h26) || (b == 8'h2C) || (b == 8'h3A) ||
            (b == 8'h3B) || (b == 8'h3D) || (b == 8'h40);
      return hit;
   endfunction

endpackage

[src/uri_path_percent_encoder.sv]
// Top level of the URI path percent-encoder: input holding register, encoder and output register.
//
//   Channel  Direction  Payload
//   req_     in         tdata = in_byte[7:0], tlast = path_end_in
//   rsp_     out        tdata = out_byte[7:0], tuser = last_of_item, tlast = path_end_out
//   csr_     in         index 0 = double_encode, index 1 = legacy_mode, data[0]
//
// Bytes that pass unchanged stream at one per cycle while rsp_tready stays high.
// An escaped byte occupies the holding register while its 3 or 5 output bytes go out one at a time,
// and req_tready stays low until its final output byte moves into the output register.
// A stall on rsp_tready freezes the output register and, through it, the holding register.
// Reset empties both registers and sets double_encode to 1 and legacy_mode to 0.
`timescale 1ns / 1ps

module uri_path_percent_encoder (
   input  logic                                clock,
   input  logic                                reset,
   // Input byte stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] in_byte
   input  logic                                req_tlast,   // path_end_in
   // Encoded byte stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] out_byte
   output logic                                rsp_tuser,   // [0] last_of_item
   output logic                                rsp_tlast,   // path_end_out
   // Configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [upe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic                                csr_data
);
   import upe_pkg::*;

   logic                        double_encode_ff;
   logic                        legacy_mode_ff;
   logic                        hold_valid_ff;
   logic [7:0]                  hold_byte_ff;
   logic                        hold_end_ff;
   logic [BEAT_COUNT_WIDTH-1:0] position_ff;
   logic [BEAT_COUNT_WIDTH-1:0] position_in;
   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_byte_ff;
   logic                        rsp_last_ff;
   logic                        rsp_end_ff;
   upe_beat_type                beat;
   logic                        advance;
   logic                        req_accept;

   upe_encoder u_encoder (
      .in_byte       (hold_byte_ff),
      .double_encode (double_encode_ff),
      .legacy_mode   (legacy_mode_ff),
      .position      (position_ff),
      .beat          (beat)
   );

   // An output byte moves on when one is held and the output register is free.
   assign advance     = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !hold_valid_ff || (advance && beat.last);
   assign req_accept  = req_tvalid && req_tready;
   assign position_in = beat.last ? '0 : position_ff + 1'b1;
   assign csr_ready   = 1'b1;

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         double_encode_ff <= 1'b1;
         legacy_mode_ff   <= 1'b0;
         hold_valid_ff    <= 1'b0;
         position_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_DOUBLE_ENCODE) begin
               double_encode_ff <= csr_data;
            end else if (csr_index == CSR_LEGACY_MODE) begin
               legacy_mode_ff <= csr_data;
            end
         end
         if (req_accept) begin
            hold_valid_ff <= 1'b1;
         end else if (advance && beat.last) begin
            hold_valid_ff <= 1'b0;
         end
         if (advance) begin
            position_ff  <= position_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of the holding and output registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_byte_ff <= req_tdata;
         hold_end_ff  <= req_tlast;
      end
      if (advance) begin
         rsp_byte_ff <= beat.data;
         rsp_last_ff <= beat.last;
         rsp_end_ff  <= beat.last && hold_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_last_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

[src/upe_encoder.sv]
// Combinational encoder: classes one byte and selects the output byte at a given position.
`timescale 1ns / 1ps

module upe_encoder (
   input  logic [7:0]                            in_byte,
   input  logic                                  double_encode,
   input  logic                                  legacy_mode,
   input  logic [upe_pkg::BEAT_COUNT_WIDTH-1:0]  position,
   output upe_pkg::upe_beat_type                 beat
);
   import upe_pkg::*;

   logic                        plain;
   logic                        sub_delim;
   logic [BEAT_COUNT_WIDTH-1:0] length;
   logic [7:0]                  hex_hi;
   logic [7:0]                  hex_lo;

   assign plain     = is_unreserved(in_byte);
   assign sub_delim = is_sub_delim(in_byte);
   assign hex_hi    = hex_digit(in_byte[7:4]);
   assign hex_lo    = hex_digit(in_byte[3:0]);

   // Length of the encoded form. In double mode a byte escaped by the legacy
   // pass gets its percent sign escaped again, and a sub-delimiter is escaped
   // once by the strict pass.
   always_comb begin
      if (plain) begin
         length = LEN_PLAIN;
      end else if (sub_delim) begin
         length = (legacy_mode && !double_encode) ? LEN_PLAIN : LEN_ESCAPE;
      end else begin
         length = double_encode ? LEN_DOUBLE : LEN_ESCAPE;
      end
   end

   // Pick the byte at the current position of "b", "%XX" or "%25XX".
   always_comb begin
      unique case (position)
         3'd0: beat.data = (length == LEN_PLAIN) ? in_byte : CHAR_PERCENT;
         3'd1: beat.data = (length == LEN_DOUBLE) ? CHAR_TWO : hex_hi;
         3'd2: beat.data = (length == LEN_DOUBLE) ? CHAR_FIVE : hex_lo;
         3'd3: beat.data = hex_hi;
         default: beat.data = hex_lo;
      endcase
      beat.last = (position == (length - LEN_PLAIN));
   end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the URI path percent-encoder: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;

   import upe_pkg::*;

   localparam int           SETTLE_CYCLES  = 6;
   localparam int unsigned  WATCHDOG_LIMIT = 2000;
   localparam int           RANDOM_PHASES  = 7;
   localparam int           PHASE_BYTES    = 50;

   // Characters that the encoder treats specially
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] MARK_CHARS [5]     = '{8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h2F};
   localparam logic [7:0] SUBDELIM_CHARS [7] = '{8'h24, 8'h26, 8'h2C, 8'h3A, 8'h3B, 8'h3D, 8'h40};

   // One expected output byte with its flags
   typedef struct packed {
      logic [7:0] data;
      logic       item_end;
      logic       path_end;
   } enc_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = 8'h00;
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic                       csr_data = 1'b0;

   // Local copy of the configuration and the queue of bytes still to come out
   logic         model_double_encode;
   logic         model_legacy_mode;
   enc_beat_type encoded_beats [$];
   logic [7:0]   enc_buf [5];
   int           enc_len;
   int           mismatch_count = 0;

   // Sender pacing
   bit        gaps_enabled = 1'b1;
   int        burst_left   = 0;

   uri_path_percent_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] in_byte
      .req_tlast  (req_tlast),    // path_end_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tuser  (rsp_tuser),    // [0] last_of_item
      .rsp_tlast  (rsp_tlast),    // path_end_out
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock generation
   initial begin
      forever #10 clock = ~clock;
   end

   // Uppercase hex character for one nibble
   function automatic logic [7:0] nibble_char(input logic [3:0] nibble);
      if (nibble <= 4'd9) begin
         return 8'h30 + 8'(nibble);
      end
      return 8'h41 + 8'(nibble) - 8'd10;
   endfunction

   // True when a byte has to be written as a percent escape
   function automatic bit needs_percent(input logic [7:0] c, input bit keep_subdelims);
      bit plain_char;
      bit sub_delim;
      plain_char = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h30 && c <= 8'h39);
      sub_delim  = 1'b0;
      foreach (MARK_CHARS[i]) begin
         if (c == MARK_CHARS[i]) plain_char = 1'b1;
      end
      foreach (SUBDELIM_CHARS[i]) begin
         if (c == SUBDELIM_CHARS[i]) sub_delim = 1'b1;
      end
      if (plain_char) return 1'b0;
      if (sub_delim) return !keep_subdelims;
      return 1'b1;
   endfunction

   // Append one pass of encoding for a byte to the working buffer
   function automatic void append_pass(input logic [7:0] c, input bit keep_subdelims);
      if (needs_percent(c, keep_subdelims)) begin
         enc_buf[enc_len]     = CH_PERCENT;
         enc_buf[enc_len + 1] = nibble_char(c[7:4]);
         enc_buf[enc_len + 2] = nibble_char(c[3:0]);
         enc_len += 3;
      end else begin
         enc_buf[enc_len] = c;
         enc_len += 1;
      end
   endfunction

   // Work out the output bytes for one accepted input byte and queue them
   function automatic void predict_encoding(input logic [7:0] c, input logic path_end);
      logic [7:0]   first_pass [3];
      int           first_len;
      enc_beat_type beat;
      enc_len = 0;
      if (model_double_encode) begin
         // Legacy pass first, then every resulting byte goes through a strict pass
         append_pass(c, 1'b1);
         first_len = enc_len;
         for (int i = 0; i < first_len; i++) first_pass[i] = enc_buf[i];
         enc_len = 0;
         for (int i = 0; i < first_len; i++) append_pass(first_pass[i], 1'b0);
      end else begin
         append_pass(c, model_legacy_mode);
      end
      for (int i = 0; i < enc_len; i++) begin
         beat.data     = enc_buf[i];
         beat.item_end = (i == enc_len - 1);
         beat.path_end = (i == enc_len - 1) ? path_end : 1'b0;
         encoded_beats.push_back(beat);
      end
   endfunction

   // Send one byte, record its expected output, then pace the next one
   task automatic send_byte(input logic [7:0] value, input logic path_end);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= path_end;
      do @(posedge clock); while (!req_tready);
      predict_encoding(value, path_end);
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stop sending and wait until every expected byte has come out
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (encoded_beats.size() != 0) @(posedge clock);
   endtask

   // Write one configuration register once the encoder has gone quiet
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic value);
      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_DOUBLE_ENCODE) begin
         model_double_encode = value;
      end else if (index == CSR_LEGACY_MODE) begin
         model_legacy_mode = value;
      end
   endtask

   // Random path byte, weighted towards the character classes
   function automatic logic [7:0] pick_path_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h41 + 8'($urandom_range(0, 25));
         1:       return 8'h61 + 8'($urandom_range(0, 25));
         2:       return 8'h30 + 8'($urandom_range(0, 9));
         3:       return MARK_CHARS[3'($urandom_range(0, 4))];
         4, 5:    return SUBDELIM_CHARS[3'($urandom_range(0, 6))];
         6:       return CH_PERCENT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Reset defaults: double encoding with every character class
   task automatic test_reset_defaults();
      logic [7:0] chars [12] = '{8'h41, 8'h7A, 8'h35, 8'h7E, 8'h2F, 8'h3D, 8'h40,
                                 8'h00, 8'hFF, CH_PERCENT, 8'h80, CH_SPACE};
      foreach (chars[i]) send_byte(chars[i], (i == 11));
   endtask

   // Single strict pass: the sub-delimiters are escaped
   task automatic test_single_strict();
      write_csr(CSR_DOUBLE_ENCODE, 1'b0);
      write_csr(CSR_LEGACY_MODE, 1'b0);
      send_byte(8'h24, 1'b0);
      send_byte(8'h26, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(CH_DEL, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // Single legacy pass: the sub-delimiters go through unchanged
   task automatic test_single_legacy();
      write_csr(CSR_LEGACY_MODE, 1'b1);
      send_byte(8'h2C, 1'b0);
      send_byte(8'h3A, 1'b0);
      send_byte(8'h3B, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // Double mode ignores the legacy setting
   task automatic test_double_ignores_legacy();
      write_csr(CSR_DOUBLE_ENCODE, 1'b1);
      send_byte(8'h40, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h0A, 1'b1);
   endtask

   // Writes to indexes beyond the register list leave the configuration alone
   task automatic test_unknown_index();
      write_csr(CSR_INDEX_WIDTH'(2), 1'b0);
      write_csr({CSR_INDEX_WIDTH{1'b1}}, 1'b0);
      send_byte(8'h26, 1'b1);
      write_csr(CSR_DOUBLE_ENCODE, 1'b0);
      write_csr(CSR_INDEX_WIDTH'(2), 1'b0);
      send_byte(8'h26, 1'b1);
   endtask

   // Random paths under every configuration, with sender gaps turned on or off at random per phase
   task automatic test_random_paths();
      int remaining;
      int path_len;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         logic dbl;
         logic leg;
         dbl = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
         leg = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_DOUBLE_ENCODE, dbl);
            write_csr(CSR_LEGACY_MODE, leg);
         end else begin
            write_csr(CSR_LEGACY_MODE, leg);
            write_csr(CSR_DOUBLE_ENCODE, dbl);
         end
         gaps_enabled = ($urandom_range(0, 3) != 0);
         burst_left   = 0;
         remaining    = PHASE_BYTES;
         while (remaining > 0) begin
            path_len = $urandom_range(1, 12);
            if (path_len > remaining) path_len = remaining;
            for (int i = 0; i < path_len; i++) begin
               send_byte(pick_path_byte(), (i == path_len - 1));
            end
            remaining -= path_len;
         end
      end
   endtask

   // Receiver: stalls on a randomly chosen pattern, and checks each byte
   int unsigned pattern_cycle = 0;
   logic [1:0]  stall_kind    = 2'd0;
   logic [7:0]  stall_mask    = 8'hFF;

   always @(posedge clock) begin : rsp_side
      enc_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (encoded_beats.size() == 0) begin
               $error("unexpected result transaction: out_byte %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = encoded_beats.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %h, actual %h", want.data, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.item_end) begin
                  $error("last_of_item: expected %b, actual %b", want.item_end, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.path_end) begin
                  $error("path_end_out: expected %b, actual %b", want.path_end, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         pattern_cycle <= pattern_cycle + 1;
         if (pattern_cycle % 48 == 0) begin
            stall_kind <= 2'($urandom_range(0, 3));
            stall_mask <= 8'($urandom_range(0, 255)) | 8'h01;
         end
         case (stall_kind)
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 2) != 0);
            default: rsp_tready <= stall_mask[pattern_cycle[2:0]];
         endcase
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence
   initial begin
      model_double_encode = 1'b1;
      model_legacy_mode   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_single_strict();
      test_single_legacy();
      test_double_ignores_legacy();
      test_unknown_index();
      test_random_paths();
      drain_outputs();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatch_count == 0 && encoded_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
